### rtl/assert_macros.svh
// Assertion macros for the top-level RTL file, which checks its own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge while reset is released.
`define BPA_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("%m: assertion failed");

// Checks that a condition implies another one in the following cycle.
`define BPA_ASSERT_NEXT(lbl, clk, rst_n, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (prop)) \
        else $error("%m: assertion failed");

`endif

### rtl/bpa_pkg.sv
// Shared constants, types and helper function of the bitmap page allocator.
package bpa_pkg;

    localparam int MAX_PAGES  = 1024;
    localparam int PAGE_SHIFT = 12;
    localparam int WORD_W     = 64;
    localparam int BIT_W      = $clog2(WORD_W);
    localparam int N_WORDS    = (MAX_PAGES + WORD_W - 1) / WORD_W;
    localparam int WIDX_W     = (N_WORDS > 1) ? $clog2(N_WORDS) : 1;
    localparam int PIDX_W     = WIDX_W + BIT_W;
    localparam int ADDR_W     = 32;
    localparam int CNT_W      = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_W      = 32;
    localparam int OUT_W      = 48;

    localparam logic [CNT_W-1:0] PAGES_RESET = CNT_W'(1024);

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_PAGES = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_VMODE = CFG_IDX_W'(2);

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_INVALID = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        MAP_NONE  = 2'd0,
        MAP_MAP   = 2'd1,
        MAP_UNMAP = 2'd2
    } t_map;

    typedef struct packed {
        logic accept;
        logic look;
        logic resolve;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_stat;

    // Page count limited to the size of the bitmap.
    function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] pc);
        logic [CNT_W-1:0] res;
        res = pc;
        if (32'(pc) > MAX_PAGES) begin
            res = CNT_W'(MAX_PAGES);
        end
        return res;
    endfunction

endpackage

### rtl/bpa_ctrl.sv
// Sequencer of the bitmap page allocator: accept, word lookup, bit resolve, commit.
module bpa_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  bpa_pkg::t_dp_stat i_stat,
    output bpa_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_LOOK   = 4'b0010,
        S_READ   = 4'b0100,
        S_COMMIT = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK:   n_state = S_READ;
            S_READ:   n_state = S_COMMIT;
            S_COMMIT: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready     = (r_state == S_IDLE);
    assign o_cmd.accept   = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.look     = (r_state == S_LOOK);
    assign o_cmd.resolve  = (r_state == S_READ);
    assign o_cmd.commit   = (r_state == S_COMMIT) && i_stat.out_free;

endmodule

### rtl/bpa_dp.sv
// Datapath of the bitmap page allocator: registers, bitmap memory, search and result.
module bpa_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bpa_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bpa_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                           i_req_type,
    input  logic [bpa_pkg::ADDR_W-1:0]     i_free_address,
    input  bpa_pkg::t_dp_cmd               i_cmd,
    output bpa_pkg::t_dp_stat              o_stat,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [bpa_pkg::OUT_W-1:0]      o_out_data
);

    // Configuration and counters.
    logic [bpa_pkg::ADDR_W-1:0] r_base;
    logic [bpa_pkg::CNT_W-1:0]  r_pages;
    logic                       r_vmode;
    logic [bpa_pkg::CNT_W-1:0]  r_free_cnt;
    logic [bpa_pkg::N_WORDS-1:0] r_valid;
    logic [bpa_pkg::N_WORDS-1:0] r_full;

    // Bitmap storage, one word of used bits per row.
    logic [bpa_pkg::WORD_W-1:0] mem [bpa_pkg::N_WORDS];

    // Request and intermediate registers.
    logic                       r_req;
    logic [bpa_pkg::ADDR_W-1:0] r_addr;
    logic [bpa_pkg::WIDX_W-1:0] r_widx;
    logic [bpa_pkg::BIT_W-1:0]  r_bit;
    logic                       r_cand;
    logic                       r_rd_valid;
    logic [bpa_pkg::WORD_W-1:0] r_rd_data;
    logic                       r_ok;
    logic [bpa_pkg::WORD_W-1:0] r_new_word;

    // Output register.
    logic                       r_out_valid;
    logic [bpa_pkg::OUT_W-1:0]  r_out_data;

    logic [bpa_pkg::CNT_W-1:0]  limit;
    logic [bpa_pkg::ADDR_W-1:0] free_off;
    logic [bpa_pkg::ADDR_W-1:0] free_idx;
    logic                       free_in_range;
    logic [bpa_pkg::WIDX_W-1:0] first_open;
    logic                       any_open;
    logic [bpa_pkg::WIDX_W-1:0] look_widx;
    logic                       look_cand;
    logic [bpa_pkg::ADDR_W-1:0] word_base;

    logic [bpa_pkg::WORD_W-1:0] cur_word;
    logic [bpa_pkg::ADDR_W-1:0] remaining;
    logic [bpa_pkg::WORD_W-1:0] tail_mask;
    logic [bpa_pkg::WORD_W-1:0] masked_word;
    logic [bpa_pkg::BIT_W-1:0]  zero_bit;
    logic                       zero_found;
    logic [bpa_pkg::BIT_W-1:0]  res_bit;
    logic                       res_ok;
    logic [bpa_pkg::WORD_W-1:0] res_word;

    logic [bpa_pkg::PIDX_W-1:0] page_idx;
    logic [bpa_pkg::ADDR_W-1:0] alloc_addr;
    logic [bpa_pkg::CNT_W-1:0]  n_free_cnt;
    logic [bpa_pkg::ADDR_W-1:0] res_addr;
    bpa_pkg::t_status           res_status;
    bpa_pkg::t_map              res_map;
    logic                       out_free;

    assign limit = bpa_pkg::eff_count(r_pages);

    // Page index of the address to free.
    assign free_off      = r_addr - r_base;
    assign free_idx      = free_off >> bpa_pkg::PAGE_SHIFT;
    assign free_in_range = free_idx < bpa_pkg::ADDR_W'(limit);

    // First bitmap word that still holds a free page.
    always_comb begin
        first_open = '0;
        any_open   = 1'b0;
        for (int k = bpa_pkg::N_WORDS - 1; k >= 0; k--) begin
            if (!r_full[k]) begin
                first_open = bpa_pkg::WIDX_W'(k);
                any_open   = 1'b1;
            end
        end
    end

    assign word_base = bpa_pkg::ADDR_W'(first_open) << bpa_pkg::BIT_W;

    always_comb begin
        if (r_req == bpa_pkg::REQ_ALLOC) begin
            look_widx = first_open;
            look_cand = (r_free_cnt != '0) && any_open
                        && (word_base < bpa_pkg::ADDR_W'(limit));
        end else begin
            look_widx = free_idx[bpa_pkg::PIDX_W-1:bpa_pkg::BIT_W];
            look_cand = free_in_range;
        end
    end

    // Resolve the bit inside the word that was read.
    assign cur_word  = r_rd_valid ? r_rd_data : '0;
    assign remaining = bpa_pkg::ADDR_W'(limit)
                       - (bpa_pkg::ADDR_W'(r_widx) << bpa_pkg::BIT_W);

    always_comb begin
        if (remaining >= bpa_pkg::ADDR_W'(bpa_pkg::WORD_W)) begin
            tail_mask = '0;
        end else begin
            tail_mask = ~((bpa_pkg::WORD_W'(1) << remaining[bpa_pkg::BIT_W-1:0])
                          - bpa_pkg::WORD_W'(1));
        end
    end

    assign masked_word = cur_word | tail_mask;

    always_comb begin
        zero_bit   = '0;
        zero_found = 1'b0;
        for (int j = bpa_pkg::WORD_W - 1; j >= 0; j--) begin
            if (!masked_word[j]) begin
                zero_bit   = bpa_pkg::BIT_W'(j);
                zero_found = 1'b1;
            end
        end
    end

    always_comb begin
        if (r_req == bpa_pkg::REQ_ALLOC) begin
            res_bit  = zero_bit;
            res_ok   = r_cand && zero_found;
            res_word = cur_word | (bpa_pkg::WORD_W'(1) << zero_bit);
        end else begin
            res_bit  = r_bit;
            res_ok   = r_cand && cur_word[r_bit];
            res_word = cur_word & ~(bpa_pkg::WORD_W'(1) << r_bit);
        end
    end

    // Result of the request.
    assign page_idx   = {r_widx, r_bit};
    assign alloc_addr = r_base + (bpa_pkg::ADDR_W'(page_idx) << bpa_pkg::PAGE_SHIFT);

    always_comb begin
        n_free_cnt = r_free_cnt;
        res_addr   = '0;
        res_map    = bpa_pkg::MAP_NONE;
        if (r_req == bpa_pkg::REQ_ALLOC) begin
            res_status = r_ok ? bpa_pkg::ST_OK : bpa_pkg::ST_FULL;
            if (r_ok) begin
                n_free_cnt = r_free_cnt - bpa_pkg::CNT_W'(1);
                res_addr   = alloc_addr;
                if (r_vmode) begin
                    res_map = bpa_pkg::MAP_MAP;
                end
            end
        end else begin
            res_status = r_ok ? bpa_pkg::ST_OK : bpa_pkg::ST_INVALID;
            if (r_ok) begin
                n_free_cnt = r_free_cnt + bpa_pkg::CNT_W'(1);
                if (r_vmode) begin
                    res_map = bpa_pkg::MAP_UNMAP;
                end
            end
        end
    end

    assign out_free        = !r_out_valid || i_out_ready;
    assign o_stat.out_free = out_free;

    // Control state: configuration, counters, row flags and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= '0;
            r_pages     <= bpa_pkg::PAGES_RESET;
            r_vmode     <= 1'b1;
            r_free_cnt  <= bpa_pkg::eff_count(bpa_pkg::PAGES_RESET);
            r_valid     <= '0;
            r_full      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    bpa_pkg::CFG_BASE: r_base <= i_cfg_data;
                    bpa_pkg::CFG_PAGES: begin
                        r_pages    <= i_cfg_data[bpa_pkg::CNT_W-1:0];
                        r_free_cnt <= bpa_pkg::eff_count(i_cfg_data[bpa_pkg::CNT_W-1:0]);
                        r_valid    <= '0;
                        r_full     <= '0;
                    end
                    bpa_pkg::CFG_VMODE: r_vmode <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
                r_free_cnt  <= n_free_cnt;
                if (r_ok) begin
                    r_valid[r_widx] <= 1'b1;
                    r_full[r_widx]  <= &r_new_word;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers and the bitmap memory.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req  <= i_req_type;
            r_addr <= i_free_address;
        end
        if (i_cmd.look) begin
            r_widx     <= look_widx;
            r_cand     <= look_cand;
            r_bit      <= free_idx[bpa_pkg::BIT_W-1:0];
            r_rd_data  <= mem[look_widx];
            r_rd_valid <= r_valid[look_widx];
        end
        if (i_cmd.resolve) begin
            r_bit      <= res_bit;
            r_ok       <= res_ok;
            r_new_word <= res_word;
        end
        if (i_cmd.commit) begin
            if (r_ok) begin
                mem[r_widx] <= r_new_word;
            end
            r_out_data <= {1'b0, n_free_cnt, res_map, res_status, res_addr};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

### rtl/bitmap_page_allocator.sv
// Top level of the bitmap page allocator: sequencer, datapath and checks.
//
// Requests arrive on the s_axis channel: tuser carries the request type
// (allocate or free) and tdata the address of the page to free. Each
// transfer produces exactly one result transfer on the m_axis channel with
// the allocated address, the status, the map action and the free count.
// Configuration is written through i_cfg_we, i_cfg_idx and i_cfg_data
// while no request is in flight; the user must ensure this, as the block
// does not. Writing the page count empties the bitmap. A request has four
// steps: the transfer, a lookup of its word (the first word with a free page
// in the row summary flags, or the word of the address to free) with a read
// of that bitmap word, a resolve of the page bit, and the commit that writes
// the word back and the result into the output register. A new request is
// taken only in the cycle after the last one's commit. When the receiver
// stalls, the result waits in the output register; a following request then
// waits at its commit step until that register is free. Reset marks every
// page free at once and restores base address 0, 1024 pages and virtual mode.
`include "assert_macros.svh"

module bitmap_page_allocator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [bpa_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [bpa_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // free_address[31:0].
    input  logic [bpa_pkg::ADDR_W-1:0]    s_axis_tdata,
    // req_type[0].
    input  logic                          s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // page_address[31:0], status[33:32], map_action[35:34], free_pages[46:36].
    output logic [bpa_pkg::OUT_W-1:0]     m_axis_tdata
);

    bpa_pkg::t_dp_cmd  cmd;
    bpa_pkg::t_dp_stat stat;

    bpa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    bpa_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_req_type     (s_axis_tuser),
        .i_free_address (s_axis_tdata),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .o_out_valid    (m_axis_tvalid),
        .i_out_ready    (m_axis_tready),
        .o_out_data     (m_axis_tdata)
    );

    `BPA_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `BPA_ASSERT(a_count_bound, i_clk, i_rst_n, !m_axis_tvalid || (32'(m_axis_tdata[46:36]) <= bpa_pkg::MAX_PAGES))
    `BPA_ASSERT(a_full_no_addr, i_clk, i_rst_n, !(m_axis_tvalid && (m_axis_tdata[33:32] == bpa_pkg::ST_FULL)) || (m_axis_tdata[31:0] == '0))
    `BPA_ASSERT(a_map_only_ok, i_clk, i_rst_n, !(m_axis_tvalid && (m_axis_tdata[35:34] != bpa_pkg::MAP_NONE)) || (m_axis_tdata[33:32] == bpa_pkg::ST_OK))

endmodule
